// File: src/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types, codes and helpers for the motion frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

	// Frame geometry
	localparam int FRAME_LEN = 9;
	localparam int POS_W     = $clog2(FRAME_LEN);
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 16;

	// Fixed byte positions inside a frame
	localparam int POS_SEQ      = 2;
	localparam int POS_FLAGS    = 3;
	localparam int POS_SPEED_LO = 4;
	localparam int POS_SPEED_HI = 5;
	localparam int POS_ACCEL_LO = 6;
	localparam int POS_ACCEL_HI = 7;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HEADER_FIRST  = 3'd0,
		CFG_HEADER_SECOND = 3'd1,
		CFG_READY_MASK    = 3'd2,
		CFG_BALANCE_MASK  = 3'd3,
		CFG_CAPTURED_MASK = 3'd4
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h5A;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hA5;
	localparam logic [BYTE_W-1:0] READY_MASK_RST    = 8'h01;
	localparam logic [BYTE_W-1:0] BALANCE_MASK_RST  = 8'h02;
	localparam logic [BYTE_W-1:0] CAPTURED_MASK_RST = 8'h04;

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_DUPLICATE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MIS_NONE     = 2'd0,
		MIS_CENTER   = 2'd1,
		MIS_CAPTURED = 2'd2
	} mission_t;

	function automatic mission_t mission_of(
		input logic [BYTE_W-1:0] flags,
		input logic [BYTE_W-1:0] balance_mask,
		input logic [BYTE_W-1:0] captured_mask
	);
		mission_t m;
		if ((flags & balance_mask) == '0)
			m = MIS_NONE;
		else if ((flags & captured_mask) != '0)
			m = MIS_CAPTURED;
		else
			m = MIS_CENTER;
		return m;
	endfunction

endpackage

// File: src/mfp_byte_if.sv
// ----------------------------------------------------------------------------
// mfp_byte_if
// Byte channel into the motion frame parser: valid/ready plus one byte.
// ----------------------------------------------------------------------------
interface mfp_byte_if;
	import mfp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

// File: src/mfp_result_if.sv
// ----------------------------------------------------------------------------
// mfp_result_if
// Result channel out of the motion frame parser: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface mfp_result_if;
	import mfp_pkg::*;

	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic [BYTE_W-1:0]        frame_sequence;
	logic [BYTE_W-1:0]        frame_flags;
	logic signed [WORD_W-1:0] planned_speed;
	logic signed [WORD_W-1:0] accel_value;
	mission_t                 start_request;

	modport source (
		output valid, output status, output frame_sequence, output frame_flags,
		output planned_speed, output accel_value, output start_request,
		input ready
	);
	modport sink (
		input valid, input status, input frame_sequence, input frame_flags,
		input planned_speed, input accel_value, input start_request,
		output ready
	);

endinterface

// File: src/motion_frame_parser.sv
// ----------------------------------------------------------------------------
// motion_frame_parser
// Byte-serial receiver for fixed-length motion frames with sum-8 checksum.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per transfer; out_ch returns exactly one
//   result per byte. Most results report "no frame end"; the result of the
//   last byte of a frame reports accepted, checksum error or duplicate, and
//   for an accepted frame carries sequence, flags, the two signed values and
//   any start request.
//   The result of a byte is registered and shows in the cycle after the byte
//   is taken. Throughput is one byte per cycle while the receiver takes
//   results, set by the single output register; the checksum is kept as a
//   running sum so the last byte needs only one compare.
//   When the receiver stalls, the result holds in the output register and a
//   new byte is taken only in a cycle where that register is being emptied.
//   Reset (arst_n low) restarts the header hunt, forgets the last sequence
//   and flags, loads the default header bytes and masks, and empties the
//   output register. Configuration writes on cfg_we/cfg_index/cfg_wdata are
//   meant for idle periods.
// ----------------------------------------------------------------------------
module motion_frame_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mfp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	mfp_byte_if.sink                         in_ch,
	mfp_result_if.source                     out_ch
);
	import mfp_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

	// Configuration
	logic [BYTE_W-1:0] header_first_q;
	logic [BYTE_W-1:0] header_second_q;
	logic [BYTE_W-1:0] ready_mask_q;
	logic [BYTE_W-1:0] balance_mask_q;
	logic [BYTE_W-1:0] captured_mask_q;

	// Parser state
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] seq_q;
	logic [BYTE_W-1:0] flags_q;
	logic [WORD_W-1:0] speed_q;
	logic [WORD_W-1:0] accel_q;
	logic              seen_q;
	logic [BYTE_W-1:0] prev_seq_q;
	logic [BYTE_W-1:0] cur_flags_q;

	// Output register
	logic out_valid_q;

	logic              accept;
	logic [BYTE_W-1:0] b;
	logic              last;
	logic              sum_ok;
	logic              dup;
	logic              frame_ok;
	status_t           status_d;
	mission_t          old_m;
	mission_t          new_m;
	logic              cur_rdy;
	logic              nxt_rdy;
	mission_t          start_d;

	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign accept       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign b            = in_ch.rx_byte;

	// Frame end decision
	assign last      = (pos_q == LAST_POS);
	assign sum_ok    = (sum_q == b);
	assign dup       = seen_q && (seq_q == prev_seq_q);
	assign frame_ok  = last && sum_ok && !dup;
	assign old_m     = mission_of(cur_flags_q, balance_mask_q, captured_mask_q);
	assign new_m     = mission_of(flags_q, balance_mask_q, captured_mask_q);
	assign cur_rdy   = (cur_flags_q & ready_mask_q) != '0;
	assign nxt_rdy   = (flags_q & ready_mask_q) != '0;

	always_comb begin
		priority if (!last)
			status_d = ST_NONE;
		else if (!sum_ok)
			status_d = ST_CHECKSUM;
		else if (dup)
			status_d = ST_DUPLICATE;
		else
			status_d = ST_ACCEPTED;
	end

	always_comb begin
		if (nxt_rdy && new_m != MIS_NONE && (!cur_rdy || old_m != new_m))
			start_d = new_m;
		else
			start_d = MIS_NONE;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
			ready_mask_q    <= READY_MASK_RST;
			balance_mask_q  <= BALANCE_MASK_RST;
			captured_mask_q <= CAPTURED_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_HEADER_FIRST:  header_first_q  <= cfg_wdata;
				CFG_HEADER_SECOND: header_second_q <= cfg_wdata;
				CFG_READY_MASK:    ready_mask_q    <= cfg_wdata;
				CFG_BALANCE_MASK:  balance_mask_q  <= cfg_wdata;
				CFG_CAPTURED_MASK: captured_mask_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Header hunt, byte position and sequence history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			seen_q      <= 1'b0;
			prev_seq_q  <= '0;
			cur_flags_q <= '0;
		end else if (accept) begin
			priority if (pos_q == POS_W'(0)) begin
				if (b == header_first_q)
					pos_q <= POS_W'(1);
			end else if (pos_q == POS_W'(1)) begin
				if (b == header_second_q)
					pos_q <= POS_W'(2);
				else if (b != header_first_q)
					pos_q <= '0;
			end else if (last) begin
				pos_q <= '0;
				if (frame_ok) begin
					seen_q      <= 1'b1;
					prev_seq_q  <= seq_q;
					cur_flags_q <= flags_q;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// Running checksum and frame fields
	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (pos_q == POS_W'(0)) begin
				sum_q <= b;
			end else if (pos_q == POS_W'(1)) begin
				// a repeated first header byte restarts the sum
				if (b == header_second_q)
					sum_q <= sum_q + b;
				else
					sum_q <= b;
			end else if (!last) begin
				sum_q <= sum_q + b;
				if (pos_q == POS_W'(POS_SEQ))      seq_q         <= b;
				if (pos_q == POS_W'(POS_FLAGS))    flags_q       <= b;
				if (pos_q == POS_W'(POS_SPEED_LO)) speed_q[7:0]  <= b;
				if (pos_q == POS_W'(POS_SPEED_HI)) speed_q[15:8] <= b;
				if (pos_q == POS_W'(POS_ACCEL_LO)) accel_q[7:0]  <= b;
				if (pos_q == POS_W'(POS_ACCEL_HI)) accel_q[15:8] <= b;
			end
		end
	end

	// Output register: fill on transfer in, drain on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_ch.status <= status_d;
			if (frame_ok) begin
				out_ch.frame_sequence <= seq_q;
				out_ch.frame_flags    <= flags_q;
				out_ch.planned_speed  <= speed_q;
				out_ch.accel_value    <= accel_q;
				out_ch.start_request  <= start_d;
			end else begin
				out_ch.frame_sequence <= '0;
				out_ch.frame_flags    <= '0;
				out_ch.planned_speed  <= '0;
				out_ch.accel_value    <= '0;
				out_ch.start_request  <= MIS_NONE;
			end
		end
	end

endmodule
